// File: sv/pvp_pkg.sv
package pvp_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int NUM_W      = 64;
   localparam int DEN_W      = 32;
   localparam int DIV_STAGES = NUM_W;
   // divider steps plus its signed output register
   localparam int DIV_LAT    = DIV_STAGES + 1;
   localparam int NDC_BITS   = 40;
   localparam int NDC_W      = NDC_BITS + 2;
   localparam int SIZE_W     = 13;
   localparam int VP_W       = NDC_W + SIZE_W + 1;

   typedef enum logic [2:0] {
      CSR_X_SCALE       = 3'd0,
      CSR_Y_SCALE       = 3'd1,
      CSR_Z_SCALE       = 3'd2,
      CSR_Z_BIAS        = 3'd3,
      CSR_DEPTH_OFFSET  = 3'd4,
      CSR_SCREEN_WIDTH  = 3'd5,
      CSR_SCREEN_HEIGHT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic               tri_end;
   } pvp_req_type;

   typedef struct packed {
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic signed [31:0] depth_out;
      logic               w_zero;
      logic               saturated;
      logic               tri_end_out;
   } pvp_rsp_type;

   typedef struct packed {
      logic wz;
      logic sat;
      logic tri_end;
   } pvp_side_type;

endpackage

// File: sv/pvp_div.sv
module pvp_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [pvp_pkg::NUM_W-1:0]    num,
   input  logic [pvp_pkg::DEN_W-1:0]    den,
   input  logic                         neg,
   output logic signed [pvp_pkg::NUM_W:0] quot
);
   import pvp_pkg::*;

   logic [DEN_W-1:0] r_ff [DIV_STAGES];
   logic [NUM_W-1:0] n_ff [DIV_STAGES];
   logic [DEN_W-1:0] d_ff [DIV_STAGES];
   logic             s_ff [DIV_STAGES];
   logic signed [NUM_W:0] q_ff;

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_stage
         logic [DEN_W-1:0] r_prev;
         logic [DEN_W-1:0] d_prev;
         logic [NUM_W-1:0] n_prev;
         logic             s_prev;
         logic [DEN_W:0]   t;
         logic [DEN_W:0]   diff;
         logic             take;

         if (k == 0) begin : g_first
            assign r_prev = '0;
            assign d_prev = den;
            assign n_prev = num;
            assign s_prev = neg;
         end else begin : g_next
            assign r_prev = r_ff[k-1];
            assign d_prev = d_ff[k-1];
            assign n_prev = n_ff[k-1];
            assign s_prev = s_ff[k-1];
         end

         // one restoring step: quotient bits shift in behind the dividend
         assign t    = {r_prev, n_prev[NUM_W-1]};
         assign diff = t - {1'b0, d_prev};
         assign take = !diff[DEN_W];

         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[k] <= take ? diff[DEN_W-1:0] : t[DEN_W-1:0];
               n_ff[k] <= {n_prev[NUM_W-2:0], take};
               d_ff[k] <= d_prev;
               s_ff[k] <= s_prev;
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         if (s_ff[DIV_STAGES-1]) begin
            q_ff <= -$signed({1'b0, n_ff[DIV_STAGES-1]});
         end else begin
            q_ff <= $signed({1'b0, n_ff[DIV_STAGES-1]});
         end
      end
   end

   assign quot = q_ff;

endmodule

// File: sv/perspective_vertex_project.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  pvp_req_type (vertex, triangle end)
// rsp      out        rsp_valid/rsp_ready  pvp_rsp_type (screen x/y, depth, flags)
// csr      in         csr_valid/csr_ready  csr_index, csr_data (register write)
//
// One vertex per cycle unless a held result stalls; stages A-C feed the 64-step
// restoring dividers (one quotient bit per stage) for x, y and depth, then D-F.
// Synchronous reset clears all valid bits and loads the register defaults.
// A held result stalls the whole pipeline; req_ready drops in the same cycle.
// csr_ready is always high.
module perspective_vertex_project (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pvp_pkg::pvp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pvp_pkg::pvp_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data
);
   import pvp_pkg::*;

   function automatic logic signed [31:0] sat32(input logic signed [NUM_W:0] v);
      logic signed [31:0] r;
      if (v > 65'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -65'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic ovf32(input logic signed [NUM_W:0] v);
      return (v > 65'sd2147483647) || (v < -65'sd2147483648);
   endfunction

   function automatic logic [NUM_W-1:0] mag64(input logic signed [NUM_W-1:0] v);
      return v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
   endfunction

   logic signed [31:0] x_scale_ff, y_scale_ff, z_scale_ff, z_bias_ff, depth_offset_ff;
   logic [SIZE_W-1:0]  screen_width_ff, screen_height_ff;

   logic adv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff       <= 32'sd32768;
         y_scale_ff       <= 32'sd65536;
         z_scale_ff       <= 32'sd65543;
         z_bias_ff        <= -32'sd6554;
         depth_offset_ff  <= 32'sd65536;
         screen_width_ff  <= SIZE_W'(128);
         screen_height_ff <= SIZE_W'(64);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_X_SCALE:       x_scale_ff       <= csr_data;
            CSR_Y_SCALE:       y_scale_ff       <= csr_data;
            CSR_Z_SCALE:       z_scale_ff       <= csr_data;
            CSR_Z_BIAS:        z_bias_ff        <= csr_data;
            CSR_DEPTH_OFFSET:  depth_offset_ff  <= csr_data;
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_data[SIZE_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // stage A: w = z + offset, saturated
   logic               a_vld_ff;
   logic signed [31:0] a_x_ff, a_y_ff, a_w_ff;
   logic               a_sat_ff, a_tri_ff;
   logic [32:0]        w_sum;
   logic               w_ovf;
   logic signed [31:0] w_in;

   assign w_sum = {req_data.vert_z[31], req_data.vert_z} + {depth_offset_ff[31], depth_offset_ff};
   assign w_ovf = w_sum[32] != w_sum[31];
   assign w_in  = w_ovf ? (w_sum[32] ? 32'sh80000000 : 32'sh7fffffff) : w_sum[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_x_ff   <= req_data.vert_x;
         a_y_ff   <= req_data.vert_y;
         a_w_ff   <= w_in;
         a_sat_ff <= w_ovf;
         a_tri_ff <= req_data.tri_end;
      end
   end

   // stage B: the three products
   logic                    b_vld_ff;
   logic signed [NUM_W-1:0] b_cx_ff, b_cy_ff, b_pz_ff;
   logic signed [31:0]      b_w_ff;
   pvp_side_type            b_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_cx_ff   <= a_x_ff * x_scale_ff;
         b_cy_ff   <= a_y_ff * y_scale_ff;
         b_pz_ff   <= a_w_ff * z_scale_ff;
         b_w_ff    <= a_w_ff;
         b_side_ff <= '{wz: (a_w_ff == 32'sd0), sat: a_sat_ff, tri_end: a_tri_ff};
      end
   end

   // stage C: bias, w-zero bypass (divide by one), sign and magnitude
   logic                    c_vld_ff;
   logic [NUM_W-1:0]        c_mx_ff, c_my_ff, c_mz_ff;
   logic                    c_nx_ff, c_ny_ff, c_nz_ff;
   logic [DEN_W-1:0]        c_den_ff;
   pvp_side_type            c_side_ff;
   logic signed [NUM_W-1:0] cz, nx_in, ny_in, nz_in;
   logic                    w_neg;

   assign cz    = b_pz_ff + $signed({{(32-FRAC_BITS){z_bias_ff[31]}}, z_bias_ff,
                                     {FRAC_BITS{1'b0}}});
   assign nx_in = b_side_ff.wz ? (b_cx_ff >>> FRAC_BITS) : b_cx_ff;
   assign ny_in = b_side_ff.wz ? (b_cy_ff >>> FRAC_BITS) : b_cy_ff;
   assign nz_in = b_side_ff.wz ? (cz >>> FRAC_BITS) : cz;
   assign w_neg = b_w_ff[31];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_mx_ff   <= mag64(nx_in);
         c_my_ff   <= mag64(ny_in);
         c_mz_ff   <= mag64(nz_in);
         c_nx_ff   <= nx_in[NUM_W-1] ^ w_neg;
         c_ny_ff   <= ny_in[NUM_W-1] ^ w_neg;
         c_nz_ff   <= nz_in[NUM_W-1] ^ w_neg;
         c_den_ff  <= b_side_ff.wz ? DEN_W'(1) : (w_neg ? DEN_W'(-b_w_ff) : DEN_W'(b_w_ff));
         c_side_ff <= b_side_ff;
      end
   end

   // dividers
   logic signed [NUM_W:0] qx, qy, qz;

   pvp_div u_div_x (.clock(clock), .en(adv), .num(c_mx_ff), .den(c_den_ff),
                    .neg(c_nx_ff), .quot(qx));
   pvp_div u_div_y (.clock(clock), .en(adv), .num(c_my_ff), .den(c_den_ff),
                    .neg(c_ny_ff), .quot(qy));
   pvp_div u_div_z (.clock(clock), .en(adv), .num(c_mz_ff), .den(c_den_ff),
                    .neg(c_nz_ff), .quot(qz));

   logic [DIV_LAT-1:0] dv_ff;
   pvp_side_type       ds_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (adv) begin
         dv_ff <= {dv_ff[DIV_LAT-2:0], c_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ds_ff[0] <= c_side_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            ds_ff[i] <= ds_ff[i-1];
         end
      end
   end

   // stage D: clamp to the NDC limit, add one, saturate depth
   logic                     d_vld_ff;
   logic signed [NDC_W-1:0]  d_vx_ff, d_vy_ff;
   logic signed [31:0]       d_z_ff;
   pvp_side_type             d_side_ff;
   logic signed [NDC_W-1:0]  vx_in, vy_in;

   function automatic logic signed [NDC_W-1:0] ndc_plus_one(input logic signed [NUM_W:0] q);
      logic signed [NUM_W:0] lim;
      logic signed [NDC_W-1:0] c;
      lim = $signed((NUM_W+1)'(1) << NDC_BITS);
      if (q > lim) begin
         c = lim[NDC_W-1:0];
      end else if (q < -lim) begin
         c = -lim[NDC_W-1:0];
      end else begin
         c = q[NDC_W-1:0];
      end
      return c + $signed(NDC_W'(1) << FRAC_BITS);
   endfunction

   assign vx_in = ndc_plus_one(qx);
   assign vy_in = ndc_plus_one(qy);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= dv_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_vx_ff   <= vx_in;
         d_vy_ff   <= vy_in;
         d_z_ff    <= sat32(qz);
         d_side_ff <= '{wz: ds_ff[DIV_LAT-1].wz,
                        sat: ds_ff[DIV_LAT-1].sat | ovf32(qz),
                        tri_end: ds_ff[DIV_LAT-1].tri_end};
      end
   end

   // stage E: viewport multiply
   logic                    e_vld_ff;
   logic signed [VP_W-1:0]  e_px_ff, e_py_ff;
   logic signed [31:0]      e_z_ff;
   pvp_side_type            e_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_px_ff   <= d_vx_ff * $signed({1'b0, screen_width_ff});
         e_py_ff   <= d_vy_ff * $signed({1'b0, screen_height_ff});
         e_z_ff    <= d_z_ff;
         e_side_ff <= d_side_ff;
      end
   end

   // stage F: halve with floor, saturate, output register
   logic                  rsp_vld_ff;
   pvp_rsp_type           rsp_ff;
   logic signed [NUM_W:0] hx, hy;

   assign hx = (NUM_W+1)'(e_px_ff >>> 1);
   assign hy = (NUM_W+1)'(e_py_ff >>> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.screen_x    <= sat32(hx);
         rsp_ff.screen_y    <= sat32(hy);
         rsp_ff.depth_out   <= e_z_ff;
         rsp_ff.w_zero      <= e_side_ff.wz;
         rsp_ff.saturated   <= e_side_ff.sat | ovf32(hx) | ovf32(hy);
         rsp_ff.tri_end_out <= e_side_ff.tri_end;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
